FILE: hdl/bary2d_pkg.sv
// Types, widths and helpers shared by the 2D barycentric weight pipeline.
package bary2d_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_WIDTH = 32;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int DET_WIDTH   = PROD_WIDTH + 1;
  localparam int MAG_WIDTH   = DET_WIDTH - 1;
  localparam int QINT_BITS   = WEIGHT_WIDTH - FRAC_BITS + 1;
  localparam int QUO_WIDTH   = QINT_BITS + FRAC_BITS + 1;
  localparam int DIV_STEPS   = QUO_WIDTH;
  localparam int REM_WIDTH   = MAG_WIDTH + 1;
  localparam int CLAMP_WIDTH = WEIGHT_WIDTH + 2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_a_x;
    logic signed [COORD_WIDTH-1:0] vertex_a_y;
    logic signed [COORD_WIDTH-1:0] vertex_b_x;
    logic signed [COORD_WIDTH-1:0] vertex_b_y;
    logic signed [COORD_WIDTH-1:0] vertex_c_x;
    logic signed [COORD_WIDTH-1:0] vertex_c_y;
    logic signed [COORD_WIDTH-1:0] query_x;
    logic signed [COORD_WIDTH-1:0] query_y;
  } request_t;

  typedef struct packed {
    logic signed [WEIGHT_WIDTH-1:0] weight_a;
    logic signed [WEIGHT_WIDTH-1:0] weight_b;
    logic signed [WEIGHT_WIDTH-1:0] weight_c;
    logic                           degenerate;
  } result_t;

  typedef struct packed {
    logic [REM_WIDTH-1:0] rem;
    logic [QUO_WIDTH-1:0] quo;
  } div_state_t;

endpackage

FILE: hdl/bary2d_div.sv
// Pipelined restoring divider: one quotient bit per stage, rounded, saturated.
module bary2d_div (
  input  logic                                          clk,
  input  logic                                          advance,
  input  logic signed [bary2d_pkg::DET_WIDTH-1:0]       num,
  input  logic signed [bary2d_pkg::DET_WIDTH-1:0]       den,
  output logic signed [bary2d_pkg::WEIGHT_WIDTH-1:0]    weight
);

  localparam int N  = bary2d_pkg::DIV_STEPS;
  localparam int MW = bary2d_pkg::MAG_WIDTH;
  localparam int RW = bary2d_pkg::REM_WIDTH;
  localparam int QW = bary2d_pkg::QUO_WIDTH;
  localparam int FB = bary2d_pkg::FRAC_BITS;
  localparam int WW = bary2d_pkg::WEIGHT_WIDTH;
  localparam int HB = QW - FB;

  logic [MW-1:0]          dmag [0:N];
  logic                   neg  [0:N];
  logic                   ovf  [0:N];
  bary2d_pkg::div_state_t st   [0:N];

  logic [MW-1:0] n0;
  logic [MW-1:0] d0;

  always_comb begin
    n0 = num[bary2d_pkg::DET_WIDTH-1] ? MW'(-num) : MW'(num);
    d0 = den[bary2d_pkg::DET_WIDTH-1] ? MW'(-den) : MW'(den);
  end

  // Seed the remainder with the numerator bits above the quotient window.
  always_ff @(posedge clk) begin
    if (advance) begin
      dmag[0]   <= d0;
      neg[0]    <= num[bary2d_pkg::DET_WIDTH-1] ^ den[bary2d_pkg::DET_WIDTH-1];
      ovf[0]    <= (n0 >> HB) >= d0;
      st[0].rem <= RW'(n0 >> HB);
      st[0].quo <= {n0[HB-1:0], {FB{1'b0}}};
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    logic [RW:0]   trial;
    logic [RW-1:0] rem_next;
    logic          qbit;
    always_comb begin
      trial    = {st[s].rem, st[s].quo[QW-1]};
      qbit     = trial >= (RW+1)'(dmag[s]);
      rem_next = qbit ? RW'(trial - (RW+1)'(dmag[s])) : RW'(trial);
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        dmag[s+1]   <= dmag[s];
        neg[s+1]    <= neg[s];
        ovf[s+1]    <= ovf[s];
        st[s+1].rem <= rem_next;
        st[s+1].quo <= {st[s].quo[QW-2:0], qbit};
      end
    end
  end

  logic [QW:0] mag;
  logic        round_up;
  logic        sat_pos;
  logic        sat_neg;

  always_comb begin
    round_up = {st[N].rem, 1'b0} >= (RW+1)'(dmag[N]);
    mag      = {1'b0, st[N].quo} + (QW+1)'(round_up);
    sat_pos  = ovf[N] || (mag > (QW+1)'({(WW-1){1'b1}}));
    sat_neg  = ovf[N] || (mag > (QW+1)'({1'b1, {(WW-1){1'b0}}}));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (neg[N]) begin
        weight <= sat_neg ? {1'b1, {(WW-1){1'b0}}} : WW'(-mag);
      end else begin
        weight <= sat_pos ? {1'b0, {(WW-1){1'b1}}} : WW'(mag);
      end
    end
  end

endmodule

FILE: hdl/barycentric_coordinates_2d_top.sv
// Barycentric weights of a 2D point against a triangle, fully pipelined.
//
// request channel: request/request_valid/request_stall carry the three vertices and
// the query point; result/result_valid/result_stall carry weight_a, weight_b,
// weight_c (signed, 16 fraction bits, saturated) and the degenerate flag.
// One request enters every cycle while the output is not stalled.
// The chain of one-bit divider stages makes up most of the pipeline depth.
// A result register at the end holds a finished result; the pipeline keeps
// accepting while it is empty or being taken, and freezes as a whole when a
// stalled result blocks the head, so nothing is lost or repeated.
// A zero determinant gives zero weights with degenerate set.
// Reset clears all valid bits; no request is in flight afterwards.
// Throughput: one result per cycle while the output is not stalled.
//
//
module barycentric_coordinates_2d_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  request_valid,
  output logic                  request_stall,
  input  bary2d_pkg::request_t  request,
  output logic                  result_valid,
  input  logic                  result_stall,
  output bary2d_pkg::result_t   result
);

  localparam int DW = bary2d_pkg::DIFF_WIDTH;
  localparam int PW = bary2d_pkg::PROD_WIDTH;
  localparam int TW = bary2d_pkg::DET_WIDTH;
  localparam int WW = bary2d_pkg::WEIGHT_WIDTH;
  localparam int CW = bary2d_pkg::CLAMP_WIDTH;
  localparam int DEPTH = bary2d_pkg::DIV_STEPS + 6;
  localparam logic signed [CW-1:0] WC_ONE = CW'(64'sd1 <<< bary2d_pkg::FRAC_BITS);
  localparam logic signed [CW-1:0] WC_MAX = CW'((64'sd1 <<< (WW-1)) - 64'sd1);
  localparam logic signed [CW-1:0] WC_MIN = CW'(-(64'sd1 <<< (WW-1)));

  logic advance;
  logic [DEPTH-1:0] valid;

  assign advance       = !(result_valid && result_stall);
  assign request_stall = !advance;

  // Stage 1: differences from C.
  logic signed [DW-1:0] x1, y1, a1, b1, c1, d1;
  always_ff @(posedge clk) begin
    if (advance) begin
      x1 <= DW'(request.query_x)    - DW'(request.vertex_c_x);
      y1 <= DW'(request.query_y)    - DW'(request.vertex_c_y);
      a1 <= DW'(request.vertex_a_x) - DW'(request.vertex_c_x);
      b1 <= DW'(request.vertex_b_x) - DW'(request.vertex_c_x);
      c1 <= DW'(request.vertex_a_y) - DW'(request.vertex_c_y);
      d1 <= DW'(request.vertex_b_y) - DW'(request.vertex_c_y);
    end
  end

  // Stage 2: products.
  logic signed [PW-1:0] ad2, bc2, xd2, by2, ay2, xc2;
  always_ff @(posedge clk) begin
    if (advance) begin
      ad2 <= a1 * d1;
      bc2 <= b1 * c1;
      xd2 <= x1 * d1;
      by2 <= b1 * y1;
      ay2 <= a1 * y1;
      xc2 <= x1 * c1;
    end
  end

  // Stage 3: determinant and numerators.
  logic signed [TW-1:0] det3, na3, nb3;
  always_ff @(posedge clk) begin
    if (advance) begin
      det3 <= TW'(ad2) - TW'(bc2);
      na3  <= TW'(xd2) - TW'(by2);
      nb3  <= TW'(ay2) - TW'(xc2);
    end
  end

  logic signed [WW-1:0] wa, wb;

  bary2d_div u_div_a (.clk(clk), .advance(advance), .num(na3), .den(det3), .weight(wa));
  bary2d_div u_div_b (.clk(clk), .advance(advance), .num(nb3), .den(det3), .weight(wb));

  logic degen [0:bary2d_pkg::DIV_STEPS+1];
  always_ff @(posedge clk) begin
    if (advance) begin
      degen[0] <= det3 == '0;
    end
  end
  for (genvar s = 0; s < bary2d_pkg::DIV_STEPS + 1; s++) begin : g_degen
    always_ff @(posedge clk) begin
      if (advance) begin
        degen[s+1] <= degen[s];
      end
    end
  end

  logic signed [CW-1:0] wc_wide;
  logic signed [WW-1:0] wc;
  always_comb begin
    wc_wide = WC_ONE - CW'(wa) - CW'(wb);
    if (wc_wide > WC_MAX) begin
      wc = {1'b0, {(WW-1){1'b1}}};
    end else if (wc_wide < WC_MIN) begin
      wc = {1'b1, {(WW-1){1'b0}}};
    end else begin
      wc = wc_wide[WW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (advance) begin
      valid <= {valid[DEPTH-2:0], request_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.degenerate <= degen[bary2d_pkg::DIV_STEPS+1];
      result.weight_a   <= degen[bary2d_pkg::DIV_STEPS+1] ? '0 : wa;
      result.weight_b   <= degen[bary2d_pkg::DIV_STEPS+1] ? '0 : wb;
      result.weight_c   <= degen[bary2d_pkg::DIV_STEPS+1] ? '0 : wc;
    end
  end

  assign result_valid = valid[DEPTH-1];

`ifndef SYNTH
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed under stall");
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    request_stall == (result_valid && result_stall))
    else $error("request stall does not follow result stall");
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |-> result.weight_a == '0 &&
    result.weight_b == '0 && result.weight_c == '0)
    else $error("degenerate result with nonzero weight");
`endif

endmodule
